FILE: sv/atq_pkg.sv
// Shared constants and types for the alarm timer queue.
`timescale 1ns / 1ps
`default_nettype none
package atq_pkg;

  localparam logic [2:0] CMD_SET      = 3'd0;
  localparam logic [2:0] CMD_END      = 3'd1;
  localparam logic [2:0] CMD_KILL     = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_ABORT    = 3'd4;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

  localparam logic [2:0] KIND_SET_OK   = 3'd0;
  localparam logic [2:0] KIND_STOPPED  = 3'd1;
  localparam logic [2:0] KIND_FULL     = 3'd2;
  localparam logic [2:0] KIND_ENDED    = 3'd3;
  localparam logic [2:0] KIND_NOTFOUND = 3'd4;
  localparam logic [2:0] KIND_SIGNAL   = 3'd5;
  localparam logic [2:0] KIND_TICKDONE = 3'd6;
  localparam logic [2:0] KIND_ACK      = 3'd7;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_ABORT = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  // floor(n/10) == (n * RECIP10) >> 35 for every 32-bit n
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam logic [4:0]  CAP_MAX   = 5'd16;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_CALC = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_FIN  = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/atq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module atq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/alarm_timer_queue.sv
// Top level of the alarm timer queue: sequencer over the slot memories.
//
// Usage: drive a request on in_* with start high; it is taken when busy is
// low. busy falls in the same cycle as the last result of that request shows.
// Results appear on out_* for one cycle each, marked by out_strobe; the
// final one of a request has out_last set. The receiver cannot stall.
// The capacity register is written through cfg_valid/cfg_ready (always
// ready) and must only be written while busy is low.
// Steps per request, with SLOTS slots: the setup states PREP and CALC, one
// pass over the expiry and owner memories (SCAN, one slot per cycle), the
// FIN state to form the summary fields, then the results. Non-tick requests
// give one result. A tick makes a second pass over the owner memory to emit
// signals in slot order, then the tick-done result. The memory read port,
// one slot per cycle, paces both passes.
// Reset (rst_n low, synchronous): all slots free, running mode, peak zero,
// capacity 16, wake-up time all ones. Memory contents are not cleared; a
// slot's contents are only used while its valid flop is set.
`timescale 1ns / 1ps
`default_nettype none
module alarm_timer_queue #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [31:0] in_now_time,
  input  wire logic [15:0] in_delay_seconds,
  input  wire logic [31:0] in_owner_id,
  input  wire logic [3:0]  in_handle_in,
  output logic             out_strobe,
  output logic [2:0]       out_kind,
  output logic [3:0]       out_handle_out,
  output logic [31:0]      out_signal_owner,
  output logic [4:0]       out_active_count,
  output logic [4:0]       out_peak_used,
  output logic [31:0]      out_time_to_next,
  output logic             out_rearm,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = CW + 5;

  atq_pkg::state_t state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] dly_r, dly_nxt;
  logic [31:0] own_r, own_nxt;
  logic [3:0]  hin_r, hin_nxt;
  logic [4:0]  cap_r, cap_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [31:0] nw_r, nw_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] sig_r, sig_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] bound_r, bound_nxt;
  logic [31:0] sexp_r, sexp_nxt;
  logic do_set_r, do_set_nxt, do_end_r, do_end_nxt, do_kill_r, do_kill_nxt;
  logic do_trun_r, do_trun_nxt, do_tall_r, do_tall_nxt, do_shut_r, do_shut_nxt;
  logic [2:0]  rkind_r, rkind_nxt;
  logic [3:0]  rhand_r, rhand_nxt;
  logic        rrearm_r, rrearm_nxt;
  logic        claim_r, claim_nxt;
  logic [31:0] min_r, min_nxt;
  logic [31:0] ttn_r, ttn_nxt;
  logic [IW:0] rd_cnt_r, rd_cnt_nxt;
  logic        p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;

  logic        o_stb_r, o_stb_nxt;
  logic [2:0]  o_kind_r, o_kind_nxt;
  logic [3:0]  o_hand_r, o_hand_nxt;
  logic [31:0] o_own_r, o_own_nxt;
  logic        o_rearm_r, o_rearm_nxt;
  logic        o_last_r, o_last_nxt;

  logic          exp_we, own_we;
  logic [31:0]   exp_wd, exp_rd, own_rd;
  logic [IW-1:0] raddr;

  logic [4:0]  usable;
  logic [32:0] set_sum;
  logic [15:0] dly_eff;
  logic [35:0] qp, bnd;
  logic        v, nv;
  logic [31:0] e, ne;

  assign raddr     = rd_cnt_r[IW-1:0];
  assign busy      = (state_r != atq_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  atq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_exp_ram (
    .clk(clk), .we(exp_we), .waddr(p_idx_r), .wdata(exp_wd),
    .raddr(raddr), .rdata(exp_rd)
  );

  atq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_own_ram (
    .clk(clk), .we(own_we), .waddr(p_idx_r), .wdata(own_r),
    .raddr(raddr), .rdata(own_rd)
  );

  always_comb begin
    usable = cap_r;
    if (usable < 5'd1) usable = 5'd1;
    if (usable > atq_pkg::CAP_MAX) usable = atq_pkg::CAP_MAX;
    if (32'(usable) > 32'(SLOTS)) usable = 5'(SLOTS);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r; now_nxt = now_r; dly_nxt = dly_r; own_nxt = own_r;
    hin_nxt = hin_r; cap_nxt = cap_r; mode_nxt = mode_r; cnt_nxt = cnt_r;
    peak_nxt = peak_r; nw_nxt = nw_r; valid_nxt = valid_r; sig_nxt = sig_r;
    prod_nxt = prod_r; bound_nxt = bound_r; sexp_nxt = sexp_r;
    do_set_nxt = do_set_r; do_end_nxt = do_end_r; do_kill_nxt = do_kill_r;
    do_trun_nxt = do_trun_r; do_tall_nxt = do_tall_r; do_shut_nxt = do_shut_r;
    rkind_nxt = rkind_r; rhand_nxt = rhand_r; rrearm_nxt = rrearm_r;
    claim_nxt = claim_r; min_nxt = min_r; ttn_nxt = ttn_r;
    rd_cnt_nxt = rd_cnt_r; p_vld_nxt = 1'b0; p_idx_nxt = p_idx_r;
    o_stb_nxt = 1'b0; o_kind_nxt = o_kind_r; o_hand_nxt = o_hand_r;
    o_own_nxt = o_own_r; o_rearm_nxt = o_rearm_r; o_last_nxt = o_last_r;
    exp_we = 1'b0; own_we = 1'b0; exp_wd = exp_rd;
    dly_eff = '0; set_sum = '0; qp = '0; bnd = '0;
    v = 1'b0; nv = 1'b0; e = '0; ne = '0;

    if (cfg_valid && cfg_ready) cap_nxt = cfg_data;

    unique case (state_r)
      atq_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_command; now_nxt = in_now_time; dly_nxt = in_delay_seconds;
          own_nxt = in_owner_id; hin_nxt = in_handle_in;
          state_nxt = atq_pkg::ST_PREP;
        end
      end
      atq_pkg::ST_PREP: begin
        prod_nxt = 64'(now_r) * 64'(atq_pkg::RECIP10);
        dly_eff = (mode_r == atq_pkg::MODE_ABORT) ? 16'd1 : dly_r;
        set_sum = {1'b0, now_r} + {17'd0, dly_eff};
        sexp_nxt = set_sum[32] ? atq_pkg::ALL_ONES : set_sum[31:0];
        state_nxt = atq_pkg::ST_CALC;
      end
      atq_pkg::ST_CALC: begin
        // next 10-second boundary: (floor(now/10)+1)*10, saturated
        qp = {7'd0, prod_r[63:35]} + 36'd1;
        bnd = (qp << 3) + (qp << 1);
        bound_nxt = (bnd[35:32] != 4'd0) ? atq_pkg::ALL_ONES : bnd[31:0];
        do_set_nxt = 1'b0; do_end_nxt = 1'b0; do_kill_nxt = 1'b0;
        do_trun_nxt = 1'b0; do_tall_nxt = 1'b0; do_shut_nxt = 1'b0;
        rkind_nxt = atq_pkg::KIND_ACK; rhand_nxt = '0; rrearm_nxt = 1'b0;
        claim_nxt = 1'b0; sig_nxt = '0; min_nxt = atq_pkg::ALL_ONES;
        case (cmd_r)
          atq_pkg::CMD_SET: begin
            if (mode_r == atq_pkg::MODE_STOP) begin
              rkind_nxt = atq_pkg::KIND_STOPPED;
            end else if (KW'(cnt_r) >= KW'(usable)) begin
              rkind_nxt = atq_pkg::KIND_FULL;
            end else begin
              do_set_nxt = 1'b1;
              rkind_nxt = atq_pkg::KIND_SET_OK;
              cnt_nxt = cnt_r + CW'(1);
              if (cnt_r + CW'(1) > peak_r) peak_nxt = cnt_r + CW'(1);
              if (nw_r > sexp_r) begin
                rrearm_nxt = 1'b1;
                nw_nxt = sexp_r;
              end
            end
          end
          atq_pkg::CMD_END: begin
            do_end_nxt = 1'b1;
            rkind_nxt = atq_pkg::KIND_NOTFOUND;
            rhand_nxt = hin_r;
          end
          atq_pkg::CMD_KILL: begin
            if (mode_r == atq_pkg::MODE_RUN) begin
              do_kill_nxt = 1'b1;
              rkind_nxt = atq_pkg::KIND_NOTFOUND;
            end
          end
          atq_pkg::CMD_TICK: begin
            rkind_nxt = atq_pkg::KIND_TICKDONE;
            if (mode_r == atq_pkg::MODE_RUN) do_trun_nxt = 1'b1;
            else do_tall_nxt = 1'b1;
          end
          atq_pkg::CMD_ABORT: begin
            if (mode_r != atq_pkg::MODE_STOP) begin
              mode_nxt = atq_pkg::MODE_ABORT;
              rrearm_nxt = (cnt_r != '0);
            end
          end
          atq_pkg::CMD_SHUTDOWN: begin
            if (mode_r != atq_pkg::MODE_STOP) begin
              mode_nxt = atq_pkg::MODE_STOP;
              do_shut_nxt = 1'b1;
              cnt_nxt = '0;
              nw_nxt = atq_pkg::ALL_ONES;
            end
          end
          default: ;
        endcase
        rd_cnt_nxt = '0;
        state_nxt = atq_pkg::ST_SCAN;
      end
      atq_pkg::ST_SCAN: begin
        if (rd_cnt_r < (IW+1)'(SLOTS)) begin
          rd_cnt_nxt = rd_cnt_r + (IW+1)'(1);
          p_vld_nxt = 1'b1;
          p_idx_nxt = rd_cnt_r[IW-1:0];
        end
        if (p_vld_r) begin
          v = valid_r[p_idx_r];
          e = exp_rd;
          nv = v;
          ne = e;
          if (do_set_r && !v && !claim_r) begin
            claim_nxt = 1'b1;
            nv = 1'b1; ne = sexp_r;
            exp_we = 1'b1; own_we = 1'b1;
            rhand_nxt = 4'(p_idx_r);
          end
          if (do_end_r && v && (32'(p_idx_r) == 32'(hin_r))) begin
            nv = 1'b0;
            cnt_nxt = cnt_r - CW'(1);
            rkind_nxt = atq_pkg::KIND_ENDED;
          end
          if (do_kill_r && v && !claim_r && (own_rd == own_r)) begin
            claim_nxt = 1'b1;
            ne = '0; exp_we = 1'b1;
            nw_nxt = '0;
            rkind_nxt = atq_pkg::KIND_ACK;
            rhand_nxt = 4'(p_idx_r);
            rrearm_nxt = 1'b1;
          end
          if (do_trun_r && v && (e <= now_r)) begin
            sig_nxt[p_idx_r] = 1'b1;
            ne = bound_r; exp_we = 1'b1;
          end
          if (do_tall_r && v) sig_nxt[p_idx_r] = 1'b1;
          if (do_shut_r) nv = 1'b0;
          valid_nxt[p_idx_r] = nv;
          exp_wd = ne;
          if (nv && (ne < min_r)) min_nxt = ne;
          if (32'(p_idx_r) == 32'(SLOTS - 1)) state_nxt = atq_pkg::ST_FIN;
        end
      end
      atq_pkg::ST_FIN: begin
        ttn_nxt = ((cnt_r != '0) && (min_r > now_r)) ? (min_r - now_r) : '0;
        if (do_trun_r || do_tall_r) begin
          if (cnt_r == '0) nw_nxt = atq_pkg::ALL_ONES;
          else if (do_tall_r) nw_nxt = (now_r == atq_pkg::ALL_ONES) ? now_r
                                                                     : now_r + 32'd1;
          else nw_nxt = min_r;
        end
        rd_cnt_nxt = '0;
        state_nxt = atq_pkg::ST_EMIT;
      end
      atq_pkg::ST_EMIT: begin
        if (!(do_trun_r || do_tall_r)) begin
          o_stb_nxt = 1'b1; o_kind_nxt = rkind_r; o_hand_nxt = rhand_r;
          o_own_nxt = '0; o_rearm_nxt = rrearm_r; o_last_nxt = 1'b1;
          state_nxt = atq_pkg::ST_IDLE;
        end else begin
          if (rd_cnt_r < (IW+1)'(SLOTS)) begin
            rd_cnt_nxt = rd_cnt_r + (IW+1)'(1);
            p_vld_nxt = 1'b1;
            p_idx_nxt = rd_cnt_r[IW-1:0];
          end
          if (p_vld_r) begin
            if (sig_r[p_idx_r]) begin
              o_stb_nxt = 1'b1; o_kind_nxt = atq_pkg::KIND_SIGNAL;
              o_hand_nxt = 4'(p_idx_r); o_own_nxt = own_rd;
              o_rearm_nxt = 1'b0; o_last_nxt = 1'b0;
            end
            if (32'(p_idx_r) == 32'(SLOTS - 1)) state_nxt = atq_pkg::ST_DONE;
          end
        end
      end
      atq_pkg::ST_DONE: begin
        o_stb_nxt = 1'b1; o_kind_nxt = atq_pkg::KIND_TICKDONE; o_hand_nxt = '0;
        o_own_nxt = '0; o_rearm_nxt = 1'b0; o_last_nxt = 1'b1;
        state_nxt = atq_pkg::ST_IDLE;
      end
      default: state_nxt = atq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atq_pkg::ST_IDLE;
      cap_r <= atq_pkg::CAP_RESET;
      mode_r <= atq_pkg::MODE_RUN;
      cnt_r <= '0;
      peak_r <= '0;
      nw_r <= atq_pkg::ALL_ONES;
      valid_r <= '0;
      p_vld_r <= 1'b0;
      o_stb_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r <= cap_nxt;
      mode_r <= mode_nxt;
      cnt_r <= cnt_nxt;
      peak_r <= peak_nxt;
      nw_r <= nw_nxt;
      valid_r <= valid_nxt;
      p_vld_r <= p_vld_nxt;
      o_stb_r <= o_stb_nxt;
    end
    cmd_r <= cmd_nxt; now_r <= now_nxt; dly_r <= dly_nxt; own_r <= own_nxt;
    hin_r <= hin_nxt; sig_r <= sig_nxt; prod_r <= prod_nxt;
    bound_r <= bound_nxt; sexp_r <= sexp_nxt;
    do_set_r <= do_set_nxt; do_end_r <= do_end_nxt; do_kill_r <= do_kill_nxt;
    do_trun_r <= do_trun_nxt; do_tall_r <= do_tall_nxt; do_shut_r <= do_shut_nxt;
    rkind_r <= rkind_nxt; rhand_r <= rhand_nxt; rrearm_r <= rrearm_nxt;
    claim_r <= claim_nxt; min_r <= min_nxt; ttn_r <= ttn_nxt;
    rd_cnt_r <= rd_cnt_nxt; p_idx_r <= p_idx_nxt;
    o_kind_r <= o_kind_nxt; o_hand_r <= o_hand_nxt; o_own_r <= o_own_nxt;
    o_rearm_r <= o_rearm_nxt; o_last_r <= o_last_nxt;
  end

  assign out_strobe       = o_stb_r;
  assign out_kind         = o_kind_r;
  assign out_handle_out   = o_hand_r;
  assign out_signal_owner = o_own_r;
  assign out_active_count = 5'(cnt_r);
  assign out_peak_used    = 5'(peak_r);
  assign out_time_to_next = ttn_r;
  assign out_rearm        = o_rearm_r;
  assign out_last         = o_last_r;

endmodule
`default_nettype wire
